// File: design/modular_poly_eval_unit_macros.svh
// Assertion macros used by the controller of the modular polynomial evaluation RTL.
`ifndef MODULAR_POLY_EVAL_UNIT_MACROS_SVH
`define MODULAR_POLY_EVAL_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, masked while arst_n is low.
`define MPE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, masked while arst_n is low.
`define MPE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/mpe_pkg.sv
// Package with widths, codes and controller/datapath types of the polynomial evaluator.
`default_nettype none

package mpe_pkg;

	// Residue width and derived widths.
	localparam int MOD_BITS   = 61;
	localparam int CNT_W      = $clog2(MOD_BITS + 1);
	localparam int TDATA_W    = ((MOD_BITS + 7) / 8) * 8;
	localparam int APB_DATA_W = 64;
	localparam int APB_ADDR_W = 4;

	// Register indexes, taken from paddr[3].
	localparam logic REG_MODULUS    = 1'b0;
	localparam logic REG_EVAL_POINT = 1'b1;

	typedef logic [MOD_BITS-1:0] residue_t;

	// Operation of the bit-serial modular unit.
	typedef enum logic {
		OP_REDUCE,
		OP_MUL
	} unit_op_t;

	// Which pair of operations the two units run.
	typedef enum logic [1:0] {
		PH_RED_CP,
		PH_RED_SX,
		PH_MUL
	} phase_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED_CP_GO,
		ST_RED_CP_RUN,
		ST_RED_SX_GO,
		ST_RED_SX_RUN,
		ST_MUL_GO,
		ST_MUL_RUN,
		ST_FINISH
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic   load_in;
		logic   start;
		phase_t phase;
		logic   capture;
		logic   commit;
		logic   load_out;
	} dp_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic done;
		logic last;
		logic zero_mod;
	} dp_status_t;

endpackage

`default_nettype wire

// File: design/mpe_mod_unit.sv
// Bit-serial modular unit: reduces a value or multiplies two residues, one bit per cycle.
`default_nettype none

module mpe_mod_unit import mpe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  unit_op_t op,
	input  residue_t opa,
	input  residue_t opb,
	input  residue_t modv,
	output logic     done,
	output residue_t result
);

	unit_op_t           op_q;
	residue_t           a_q;
	residue_t           b_q;
	residue_t           r_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	logic                bit_s;
	logic                inc;
	logic [MOD_BITS+1:0] addend;
	logic [MOD_BITS+1:0] sum_t;
	logic [MOD_BITS+1:0] m1;
	logic [MOD_BITS+1:0] m2;
	logic [MOD_BITS+1:0] sub1;
	logic [MOD_BITS+1:0] sub2;
	residue_t            r_next;

	// One step: r = (2r + bit) mod m for a reduction, r = (2r + bit*a) mod m for a product.
	// The sum stays below 3m, so one of two parallel subtractions brings it into range.
	always_comb begin
		bit_s  = b_q[MOD_BITS-1];
		inc    = (op_q == OP_REDUCE) ? bit_s : 1'b0;
		addend = ((op_q == OP_MUL) && bit_s) ? (MOD_BITS+2)'(a_q) : '0;
		sum_t  = {1'b0, r_q, inc} + addend;
		m1     = (MOD_BITS+2)'(modv);
		m2     = {1'b0, modv, 1'b0};
		sub1   = sum_t - m1;
		sub2   = sum_t - m2;
		if (sum_t >= m2) begin
			r_next = sub2[MOD_BITS-1:0];
		end else if (sum_t >= m1) begin
			r_next = sub1[MOD_BITS-1:0];
		end else begin
			r_next = sum_t[MOD_BITS-1:0];
		end
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(MOD_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operands and partial result.
	always_ff @(posedge clk) begin
		if (start) begin
			op_q <= op;
			a_q  <= opa;
			b_q  <= opb;
			r_q  <= '0;
		end else if (busy_q) begin
			r_q <= r_next;
			b_q <= {b_q[MOD_BITS-2:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign result = r_q;

endmodule

`default_nettype wire

// File: design/mpe_datapath.sv
// Datapath: operand registers, two modular units, final modular add and result register.
`default_nettype none

module mpe_datapath import mpe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	input  residue_t   modulus,
	input  residue_t   eval_point,
	input  residue_t   coefficient,
	input  logic       last,
	output residue_t   evaluation,
	output logic       range_error
);

	residue_t coef_q;
	logic     last_q;
	residue_t c_q;
	residue_t p_q;
	residue_t s_q;
	residue_t x_q;
	residue_t prod_cp_q;
	residue_t prod_px_q;
	residue_t sum_q;
	residue_t power_q;
	residue_t out_eval_q;
	logic     out_rerr_q;

	unit_op_t unit_op;
	residue_t opa_a;
	residue_t opb_a;
	residue_t opa_b;
	residue_t opb_b;
	logic     done_a;
	logic     done_b;
	residue_t res_a;
	residue_t res_b;

	logic [MOD_BITS:0] add_t;
	logic [MOD_BITS:0] add_sub;
	residue_t          add_res;
	residue_t          sum_new;
	residue_t          power_new;
	logic              zero_mod;
	logic              range_bad;

	// Operand selection for each phase.
	always_comb begin
		unit_op = OP_REDUCE;
		opa_a   = '0;
		opb_a   = coef_q;
		opa_b   = '0;
		opb_b   = power_q;
		case (cmd.phase)
			PH_RED_CP: begin
				unit_op = OP_REDUCE;
				opb_a   = coef_q;
				opb_b   = power_q;
			end
			PH_RED_SX: begin
				unit_op = OP_REDUCE;
				opb_a   = sum_q;
				opb_b   = eval_point;
			end
			PH_MUL: begin
				unit_op = OP_MUL;
				opa_a   = c_q;
				opb_a   = p_q;
				opa_b   = p_q;
				opb_b   = x_q;
			end
			default: begin
				unit_op = OP_REDUCE;
			end
		endcase
	end

	mpe_mod_unit u_unit_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.op     (unit_op),
		.opa    (opa_a),
		.opb    (opb_a),
		.modv   (modulus),
		.done   (done_a),
		.result (res_a)
	);

	mpe_mod_unit u_unit_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.op     (unit_op),
		.opa    (opa_b),
		.opb    (opb_b),
		.modv   (modulus),
		.done   (done_b),
		.result (res_b)
	);

	// Final modular add of the product and the reduced sum, plus special cases.
	always_comb begin
		zero_mod  = (modulus == '0);
		range_bad = (eval_point >= modulus);
		add_t     = {1'b0, prod_cp_q} + {1'b0, s_q};
		add_sub   = add_t - {1'b0, modulus};
		add_res   = (add_t >= {1'b0, modulus}) ? add_sub[MOD_BITS-1:0] : add_t[MOD_BITS-1:0];
		sum_new   = zero_mod ? '0 : add_res;
		power_new = zero_mod ? '0 : prod_px_q;
	end

	// Running sum and power: cleared to zero and one at reset and after a last beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			power_q <= MOD_BITS'(1);
		end else if (cmd.commit) begin
			if (last_q) begin
				sum_q   <= '0;
				power_q <= MOD_BITS'(1);
			end else begin
				sum_q   <= sum_new;
				power_q <= power_new;
			end
		end
	end

	// Input capture, intermediate residues and the result register.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			coef_q <= coefficient;
			last_q <= last;
		end
		if (cmd.capture) begin
			case (cmd.phase)
				PH_RED_CP: begin
					c_q <= res_a;
					p_q <= res_b;
				end
				PH_RED_SX: begin
					s_q <= res_a;
					x_q <= res_b;
				end
				PH_MUL: begin
					prod_cp_q <= res_a;
					prod_px_q <= res_b;
				end
				default: begin
				end
			endcase
		end
		if (cmd.load_out) begin
			out_eval_q <= sum_new;
			out_rerr_q <= range_bad;
		end
	end

	assign status.done     = done_a & done_b;
	assign status.last     = last_q;
	assign status.zero_mod = zero_mod;
	assign evaluation      = out_eval_q;
	assign range_error     = out_rerr_q;

endmodule

`default_nettype wire

// File: design/mpe_ctrl.sv
// Controller: sequences reductions, products and commit, and owns the beat handshakes.
`default_nettype none
`include "modular_poly_eval_unit_macros.svh"

module mpe_ctrl import mpe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = status.zero_mod ? ST_FINISH : ST_RED_CP_GO;
				end
			end
			ST_RED_CP_GO:  state_d = ST_RED_CP_RUN;
			ST_RED_CP_RUN: begin
				if (status.done) begin
					state_d = ST_RED_SX_GO;
				end
			end
			ST_RED_SX_GO:  state_d = ST_RED_SX_RUN;
			ST_RED_SX_RUN: begin
				if (status.done) begin
					state_d = ST_MUL_GO;
				end
			end
			ST_MUL_GO:     state_d = ST_MUL_RUN;
			ST_MUL_RUN: begin
				if (status.done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!status.last || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.phase    = PH_RED_CP;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_RED_CP_GO: begin
				cmd.start = 1'b1;
				cmd.phase = PH_RED_CP;
			end
			ST_RED_CP_RUN: begin
				cmd.capture = status.done;
				cmd.phase   = PH_RED_CP;
			end
			ST_RED_SX_GO: begin
				cmd.start = 1'b1;
				cmd.phase = PH_RED_SX;
			end
			ST_RED_SX_RUN: begin
				cmd.capture = status.done;
				cmd.phase   = PH_RED_SX;
			end
			ST_MUL_GO: begin
				cmd.start = 1'b1;
				cmd.phase = PH_MUL;
			end
			ST_MUL_RUN: begin
				cmd.capture = status.done;
				cmd.phase   = PH_MUL;
			end
			ST_FINISH: begin
				cmd.commit   = !status.last || out_free;
				cmd.load_out = status.last && out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// State and result-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// Checks on the sequencing.
	`MPE_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_q != ST_IDLE, "accepted beat left the controller idle")
	`MPE_ASSERT_NOW(a_done_in_run, status.done, state_q == ST_RED_CP_RUN || state_q == ST_RED_SX_RUN || state_q == ST_MUL_RUN, "unit finished outside a run state")
	`MPE_ASSERT_NEXT(a_start_not_done, cmd.start, !status.done, "unit reported done right after start")
	`MPE_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid_q, "result loaded without valid")

endmodule

`default_nettype wire

// File: design/modular_poly_eval_unit.sv
// Top level of the modular polynomial evaluator: register port, controller and datapath.
//
//  Channel  | Direction | Beat content
//  ---------+-----------+-----------------------------------------------------------
//  s_*      | in        | tdata: coefficient [60:0], zero pad; tlast: last
//  m_*      | out       | tdata: evaluation [60:0], zero pad; tuser: range_error
//  APB      | in/out    | 0x0 modulus, 0x8 eval_point; 64-bit data, pready tied high
//
// Each coefficient passes through the bit-serial modular units (one bit per cycle),
// which run three passes: reduce coefficient and power, reduce sum and point, then
// the two products. With a zero modulus a coefficient goes from idle straight to
// the finish state and no pass runs.
// Reset is asynchronous and active low; it restores modulus 2, point 0, sum 0, power 1.
// A result waits in the output register while the next coefficient is taken; a
// further last beat stalls in its final cycle until that result has been taken.
`default_nettype none

module modular_poly_eval_unit import mpe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// Coefficient stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [TDATA_W-1:0]    s_tdata,   // [60:0] coefficient
	input  logic                  s_tlast,
	// Result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_W-1:0]    m_tdata,   // [60:0] evaluation
	output logic                  m_tuser    // [0] range_error
);

	residue_t   modulus_q;
	residue_t   eval_point_q;
	logic       wr_en;
	logic       reg_sel;
	dp_cmd_t    cmd;
	dp_status_t status;
	residue_t   evaluation;
	logic       range_error;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = paddr[3];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q    <= MOD_BITS'(2);
			eval_point_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_MODULUS:    modulus_q    <= pwdata[MOD_BITS-1:0];
				REG_EVAL_POINT: eval_point_q <= pwdata[MOD_BITS-1:0];
				default:        modulus_q    <= modulus_q;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_sel)
			REG_MODULUS:    prdata = APB_DATA_W'(modulus_q);
			REG_EVAL_POINT: prdata = APB_DATA_W'(eval_point_q);
			default:        prdata = '0;
		endcase
	end

	mpe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	mpe_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.modulus     (modulus_q),
		.eval_point  (eval_point_q),
		.coefficient (s_tdata[MOD_BITS-1:0]),
		.last        (s_tlast),
		.evaluation  (evaluation),
		.range_error (range_error)
	);

	assign m_tdata = TDATA_W'(evaluation);
	assign m_tuser = range_error;

endmodule

`default_nettype wire

// File: dv/tb.sv
// Testbench for the modular polynomial evaluator: stimulus, prediction and result checks.
`timescale 1ns / 1ps

module tb;
	import mpe_pkg::*;

	localparam int SETTLE_CYCLES = 3 * (MOD_BITS + 2) + 2 + 16;
	localparam int LIMIT_CYCLES  = 1_500_000;

	typedef struct {
		residue_t evaluation;
		logic     range_error;
	} poly_eval_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [TDATA_W-1:0]    s_tdata  = '0;   // [60:0] coefficient, rest zero
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [TDATA_W-1:0]    m_tdata;         // [60:0] evaluation, rest zero
	logic                  m_tuser;         // [0] range_error

	// Shadow of the registers and the running polynomial state.
	residue_t cfg_modulus = residue_t'(2);
	residue_t cfg_point   = '0;
	residue_t acc_sum     = '0;
	residue_t acc_power   = residue_t'(1);

	poly_eval_t  expected_evals[$];
	poly_eval_t  want_eval;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int unsigned stall_left     = 0;
	int          src_idle_pct   = 0;
	int          snk_idle_pct   = 0;

	modular_poly_eval_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// Give up if the run hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Check each result beat against the oldest prediction, then pick the next ready value.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (expected_evals.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result, expected none, actual evaluation %h range_error %b",
					$time, m_tdata[MOD_BITS-1:0], m_tuser);
			end else begin
				want_eval = expected_evals.pop_front();
				if (m_tdata[MOD_BITS-1:0] !== want_eval.evaluation) begin
					mismatch_count++;
					$display("%0t: evaluation expected %h, actual %h",
						$time, want_eval.evaluation, m_tdata[MOD_BITS-1:0]);
				end
				if (m_tuser !== want_eval.range_error) begin
					mismatch_count++;
					$display("%0t: range_error expected %b, actual %b",
						$time, want_eval.range_error, m_tuser);
				end
			end
		end
		if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	function automatic residue_t random_residue();
		return residue_t'({$urandom, $urandom});
	endfunction

	function automatic residue_t random_below(input residue_t bound);
		if (bound == 0)
			return random_residue();
		return random_residue() % bound;
	endfunction

	// Mostly reduced coefficients, with extremes and unreduced values mixed in.
	function automatic residue_t pick_coefficient(input residue_t q);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 4)
			return '0;
		if (roll < 8)
			return '1;
		if (roll < 20)
			return random_residue();
		return random_below(q);
	endfunction

	function automatic residue_t pick_modulus();
		case ($urandom_range(19))
			0: return '1;
			1: return residue_t'(2);
			2: return '0;
			3: return residue_t'(1);
			4, 5: return residue_t'($urandom_range(1000, 2));
			6, 7, 8: return residue_t'($urandom);
			9, 10, 11, 12, 13: return random_residue();
			default: return random_residue() | (residue_t'(1) << (MOD_BITS - 1));
		endcase
	endfunction

	// Mostly a valid point, sometimes one at or above the modulus.
	function automatic residue_t pick_point(input residue_t q);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return q;
		if (roll < 12)
			return '1;
		if (roll < 16)
			return random_residue();
		return random_below(q);
	endfunction

	// Advance the predicted sum and power by one coefficient; queue a result on the last one.
	task automatic advance_polynomial(input residue_t coef, input logic is_last);
		logic [127:0] wide;
		residue_t     c;
		residue_t     p;
		residue_t     s;
		residue_t     x;
		poly_eval_t   res;
		if (cfg_modulus == 0) begin
			acc_sum   = '0;
			acc_power = '0;
		end else begin
			c = coef % cfg_modulus;
			p = acc_power % cfg_modulus;
			s = acc_sum % cfg_modulus;
			x = cfg_point % cfg_modulus;
			wide = c * p + s;
			wide = wide % cfg_modulus;
			acc_sum = wide[MOD_BITS-1:0];
			wide = p * x;
			wide = wide % cfg_modulus;
			acc_power = wide[MOD_BITS-1:0];
		end
		if (is_last) begin
			res.evaluation  = acc_sum;
			res.range_error = (cfg_point >= cfg_modulus);
			expected_evals.insert(expected_evals.size(), res);
			acc_sum   = '0;
			acc_power = residue_t'(1);
		end
	endtask

	// Offer one coefficient beat, with random idle cycles ahead of it.
	task automatic send_coefficient(input residue_t coef, input logic is_last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= TDATA_W'(coef);
		s_tlast  <= is_last;
		do @(posedge clk); while (!s_tready);
		advance_polynomial(coef, is_last);
	endtask

	// Register write: setup cycle, then access cycle until pready.
	task automatic write_config(input logic reg_sel, input residue_t value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 3'b000};
		pwdata  <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (reg_sel == REG_MODULUS)
			cfg_modulus = value;
		else
			cfg_point = value;
	endtask

	// Wait for every predicted result, then for a coefficient still in flight.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_evals.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Registers at their reset values: modulus 2, point 0.
	task automatic test_reset_state();
		src_idle_pct = 29;
		snk_idle_pct = 61;
		send_coefficient('1, 1'b1);
		send_coefficient('0, 1'b0);
		send_coefficient(residue_t'(1), 1'b1);
	endtask

	task automatic test_corner_cases();
		residue_t big_q;
		big_q = '1;
		// Coefficients at and above the top residue.
		wait_idle();
		write_config(REG_MODULUS, big_q);
		write_config(REG_EVAL_POINT, big_q - 1);
		send_coefficient('1, 1'b0);
		send_coefficient(big_q - 1, 1'b0);
		send_coefficient(big_q - 1, 1'b1);
		// Point equal to the modulus.
		wait_idle();
		write_config(REG_EVAL_POINT, big_q);
		send_coefficient(residue_t'(5), 1'b0);
		send_coefficient(residue_t'(7), 1'b1);
		// Point far above a small modulus.
		wait_idle();
		write_config(REG_MODULUS, residue_t'(1000003));
		send_coefficient(random_residue(), 1'b0);
		send_coefficient(random_residue(), 1'b1);
		// Point zero.
		wait_idle();
		write_config(REG_EVAL_POINT, '0);
		send_coefficient(residue_t'(3), 1'b0);
		send_coefficient(residue_t'(4), 1'b1);
		// Modulus zero.
		wait_idle();
		write_config(REG_MODULUS, '0);
		send_coefficient(residue_t'(1), 1'b0);
		send_coefficient(residue_t'(2), 1'b1);
		// Modulus one.
		wait_idle();
		write_config(REG_MODULUS, residue_t'(1));
		send_coefficient('1, 1'b0);
		send_coefficient(residue_t'(9), 1'b1);
		// Modulus changed partway through a polynomial.
		wait_idle();
		write_config(REG_MODULUS, big_q);
		write_config(REG_EVAL_POINT, random_below(big_q));
		repeat (3) send_coefficient(random_residue(), 1'b0);
		wait_idle();
		write_config(REG_MODULUS, residue_t'(1000003));
		send_coefficient(random_residue(), 1'b0);
		send_coefficient(random_residue(), 1'b1);
	endtask

	// The receiver holds off long enough that the block fills up and stalls its input.
	task automatic test_output_stall();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		wait_idle();
		write_config(REG_MODULUS, '1);
		write_config(REG_EVAL_POINT, random_residue());
		stall_left = 3000;
		repeat (25) send_coefficient(random_residue(), 1'b1);
	endtask

	// Random polynomials, with new settings every few and now and then a change mid-way.
	task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_items);
		int sent;
		int polys;
		int poly_len;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		sent  = 0;
		polys = 0;
		while (sent < n_items) begin
			if (polys % 12 == 0) begin
				wait_idle();
				write_config(REG_MODULUS, pick_modulus());
				write_config(REG_EVAL_POINT, pick_point(cfg_modulus));
			end else if (polys % 12 == 6) begin
				wait_idle();
				write_config(REG_EVAL_POINT, pick_point(cfg_modulus));
			end
			poly_len = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
			for (int i = 0; i < poly_len; i++) begin
				if (i == 1 && $urandom_range(29) == 0) begin
					wait_idle();
					write_config(REG_MODULUS, pick_modulus());
				end
				send_coefficient(pick_coefficient(cfg_modulus), i == poly_len - 1);
			end
			sent += poly_len;
			polys++;
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_corner_cases();
		test_output_stall();
		test_random_traffic(29, 61, 400);
		test_random_traffic(61, 29, 400);
		test_random_traffic(0, 0, 400);
		wait_idle();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
